// ===== design/dfr_pkg.sv =====
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared types and codes of the framed byte packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package dfr_pkg;

  // configuration register indexes
  localparam logic [2:0] RegHeadByte     = 3'd0;
  localparam logic [2:0] RegDestByte     = 3'd1;
  localparam logic [2:0] RegEndByte      = 3'd2;
  localparam logic [2:0] RegSampleOffset = 3'd3;
  localparam logic [2:0] RegSampleStride = 3'd4;
  localparam logic [2:0] RegSampleCount  = 3'd5;

  // result event codes
  localparam logic [1:0] EvData     = 2'd0;
  localparam logic [1:0] EvGood     = 2'd1;
  localparam logic [1:0] EvMismatch = 2'd2;
  localparam logic [1:0] EvBadEnd   = 2'd3;

  typedef struct packed {
    logic [7:0]  head_byte;
    logic [7:0]  dest_byte;
    logic [7:0]  end_byte;
    logic [15:0] sample_offset;
    logic [15:0] sample_stride;
    logic [15:0] sample_count;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;
  } result_t;

endpackage

`default_nettype wire

// ===== design/dfr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// dfr_cfg_regs
// Configuration register file written through the config channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dfr_cfg_regs import dfr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        wr_en_i,
  input  wire logic [2:0]  wr_index_i,
  input  wire logic [15:0] wr_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        RegHeadByte:     cfg_d.head_byte     = wr_data_i[7:0];
        RegDestByte:     cfg_d.dest_byte     = wr_data_i[7:0];
        RegEndByte:      cfg_d.end_byte      = wr_data_i[7:0];
        RegSampleOffset: cfg_d.sample_offset = wr_data_i;
        RegSampleStride: cfg_d.sample_stride = wr_data_i;
        RegSampleCount:  cfg_d.sample_count  = wr_data_i;
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.head_byte     <= 8'hAA;
      cfg_q.dest_byte     <= 8'hBF;
      cfg_q.end_byte      <= 8'hFF;
      cfg_q.sample_offset <= 16'd34;
      cfg_q.sample_stride <= 16'd189;
      cfg_q.sample_count  <= 16'd120;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== design/dfr_parser.sv =====
// ----------------------------------------------------------------------------
// dfr_parser
// Frame state machine with length, sample and check-sum tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module dfr_parser import dfr_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire cfg_t       cfg_i,
  output logic            res_valid_o,
  output result_t         res_o
);

  localparam logic [2:0] PhIdle   = 3'd0;
  localparam logic [2:0] PhSource = 3'd1;
  localparam logic [2:0] PhDest   = 3'd2;
  localparam logic [2:0] PhType   = 3'd3;
  localparam logic [2:0] PhLength = 3'd4;
  localparam logic [2:0] PhData   = 3'd5;
  localparam logic [2:0] PhCheck  = 3'd6;
  localparam logic [2:0] PhEnd    = 3'd7;

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] length_q, length_d;
  logic [15:0] rcvd_q, rcvd_d;
  logic [16:0] next_q, next_d;
  logic [15:0] taken_q, taken_d;
  logic [7:0]  sum_q, sum_d;

  logic        hit;
  logic        last;
  logic [7:0]  rem;
  logic [15:0] prod;
  logic [16:0] idx_inc;

  assign hit     = (taken_q < cfg_i.sample_count) && (next_q == {1'b0, rcvd_q});
  assign idx_inc = {1'b0, rcvd_q} + 17'd1;
  assign last    = idx_inc >= {1'b0, length_q};
  // zero stride: all remaining samples land on this byte
  assign rem     = cfg_i.sample_count[7:0] - taken_q[7:0];
  assign prod    = {8'd0, rx_byte_i} * {8'd0, rem};

  always_comb begin
    phase_d  = phase_q;
    type_d   = type_q;
    length_d = length_q;
    rcvd_d   = rcvd_q;
    next_d   = next_q;
    taken_d  = taken_q;
    sum_d    = sum_q;
    res_valid_o        = 1'b0;
    res_o.event_res    = EvData;
    res_o.data_byte    = 8'd0;
    res_o.byte_index   = 16'd0;
    res_o.frame_type   = type_q;
    res_o.frame_length = length_q;

    unique case (phase_q)
      PhIdle: begin
        if (rx_byte_i == cfg_i.head_byte) phase_d = PhSource;
      end
      PhSource: begin
        phase_d = PhDest;
      end
      PhDest: begin
        phase_d = (rx_byte_i == cfg_i.dest_byte) ? PhType : PhIdle;
        rcvd_d  = 16'd0;
      end
      PhType: begin
        type_d  = rx_byte_i;
        rcvd_d  = 16'd0;
        phase_d = PhLength;
      end
      PhLength: begin
        if (rcvd_q == 16'd0) begin
          length_d = {rx_byte_i, 8'd0};
          rcvd_d   = 16'd1;
        end else begin
          length_d = {length_q[15:8], rx_byte_i};
          rcvd_d   = 16'd0;
          next_d   = {1'b0, cfg_i.sample_offset};
          taken_d  = 16'd0;
          sum_d    = 8'd0;
          phase_d  = (length_d == 16'd0) ? PhIdle : PhData;
        end
      end
      PhData: begin
        if (hit) begin
          if (cfg_i.sample_stride == 16'd0) begin
            sum_d   = sum_q + prod[7:0];
            taken_d = cfg_i.sample_count;
          end else begin
            sum_d   = sum_q + rx_byte_i;
            taken_d = taken_q + 16'd1;
            next_d  = next_q + {1'b0, cfg_i.sample_stride};
          end
        end
        if (last) begin
          phase_d = PhCheck;
          rcvd_d  = 16'd0;
        end else begin
          rcvd_d  = idx_inc[15:0];
        end
        res_valid_o      = 1'b1;
        res_o.data_byte  = rx_byte_i;
        res_o.byte_index = rcvd_q;
      end
      PhCheck: begin
        if (rx_byte_i != sum_q) begin
          phase_d         = PhIdle;
          res_valid_o     = 1'b1;
          res_o.event_res = EvMismatch;
        end else begin
          phase_d = PhEnd;
        end
      end
      PhEnd: begin
        phase_d         = PhIdle;
        res_valid_o     = 1'b1;
        res_o.event_res = (rx_byte_i == cfg_i.end_byte) ? EvGood : EvBadEnd;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      type_q   <= 8'd0;
      length_q <= 16'd0;
      rcvd_q   <= 16'd0;
      next_q   <= 17'd0;
      taken_q  <= 16'd0;
      sum_q    <= 8'd0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      type_q   <= type_d;
      length_q <= length_d;
      rcvd_q   <= rcvd_d;
      next_q   <= next_d;
      taken_q  <= taken_d;
      sum_q    <= sum_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/dfr_out_reg.sv =====
// ----------------------------------------------------------------------------
// dfr_out_reg
// Result register holding one item for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dfr_out_reg import dfr_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t res_i,
  output logic         free_o,
  output logic         valid_o,
  input  wire logic    ready_i,
  output result_t      res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // slot is free when empty or being drained this cycle
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

// ===== design/framed_byte_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// framed_byte_packet_deframer
// Parses a byte stream into frames, forwards payload bytes and reports
// frame status (good, check mismatch, bad end byte).
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       input      in_valid_i/in_ready_o  rx_byte_i
//  out      output     out_valid_o/out_ready_i event_res_o, data_byte_o,
//                                             byte_index_o, frame_type_o,
//                                             frame_length_o
//  cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
//  one item per cycle unless a full result register holds it; each result passes
//  the input register, then the parser step into the result register
//  bytes that produce no result never wait on the output side
//  a full result register stalls only an item that produces a result
//  reset returns the parser to idle and the config registers to their defaults
// ----------------------------------------------------------------------------
`default_nettype none

module framed_byte_packet_deframer import dfr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       event_res_o,
  output logic [7:0]       data_byte_o,
  output logic [15:0]      byte_index_o,
  output logic [7:0]       frame_type_o,
  output logic [15:0]      frame_length_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  cfg_t    cfg;
  result_t res;
  result_t out_res;
  logic    res_valid;
  logic    out_free;
  logic    step;
  logic    in_valid_q, in_valid_d;
  logic [7:0] rx_byte_q;

  assign cfg_ready_o = 1'b1;

  dfr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // item in the input register moves on unless its result has nowhere to go
  assign step       = in_valid_q && (!res_valid || out_free);
  assign in_ready_o = !in_valid_q || step;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) rx_byte_q <= rx_byte_i;
  end

  dfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .rx_byte_i   (rx_byte_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  dfr_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && res_valid),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (out_res)
  );

  assign event_res_o    = out_res.event_res;
  assign data_byte_o    = out_res.data_byte;
  assign byte_index_o   = out_res.byte_index;
  assign frame_type_o   = out_res.frame_type;
  assign frame_length_o = out_res.frame_length;

endmodule

`default_nettype wire
